>>> hdl/hsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_pkg: shared types and constants of the heater safety monitor
// Item, result and register-write formats, fault bit positions, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package hsm_pkg;

   // fault bit positions (same for live and latched flags)
   localparam int unsigned FLAG_SENSOR  = 0;
   localparam int unsigned FLAG_OVER    = 1;
   localparam int unsigned FLAG_RUNAWAY = 2;
   localparam int unsigned FLAG_W       = 3;

   localparam int unsigned TEMP_W    = 16;
   localparam int unsigned DUTY_W    = 16;
   localparam int unsigned STEP_W    = 16;
   localparam int unsigned WINDOW_W  = 24;
   localparam int unsigned ELAPSED_W = 25;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 24;

   // stream payload widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [0:0] {
      OP_EVALUATE = 1'b0,
      OP_CLEAR    = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_TEMPERATURE = 2'd0,
      REG_DUTY_THRESHOLD  = 2'd1,
      REG_WINDOW_MS       = 2'd2,
      REG_MIN_RISE        = 2'd3
   } reg_index_type;

   localparam logic [TEMP_W-1:0]   RST_MAX_TEMPERATURE = 16'd4800;
   localparam logic [DUTY_W-1:0]   RST_DUTY_THRESHOLD  = 16'd32768;
   localparam logic [WINDOW_W-1:0] RST_WINDOW_MS       = 24'd60000;
   localparam logic [TEMP_W-1:0]   RST_MIN_RISE        = 16'd32;

   typedef struct packed {
      opcode_type                opcode;
      logic signed [TEMP_W-1:0]  temperature;
      logic [DUTY_W-1:0]         duty;
      logic [STEP_W-1:0]         step_ms;
      logic                      sensor_bad;
   } item_type;

   typedef struct packed {
      logic [FLAG_W-1:0] fault_flags;
      logic [FLAG_W-1:0] latched_flags;
      logic              heater_enable;
   } result_type;

   typedef struct packed {
      logic                 wen;
      reg_index_type        index;
      logic [CSR_DAT_W-1:0] wdata;
   } csr_write_type;

endpackage

>>> hdl/hsm_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsm_eval: fault evaluation and monitor state
// Holds the trip settings and the runaway window state, and works out the
// result of one item combinationally, updating state when fire is high.
// ----------------------------------------------------------------------------
module hsm_eval (
   input  logic                   clock,
   input  logic                   reset,
   input  hsm_pkg::csr_write_type csr,
   input  logic                   fire,
   input  hsm_pkg::item_type      item,
   output hsm_pkg::result_type    result
);

   // settings
   logic [hsm_pkg::TEMP_W-1:0]    max_temp_ff;
   logic [hsm_pkg::DUTY_W-1:0]    duty_thr_ff;
   logic [hsm_pkg::WINDOW_W-1:0]  window_ff;
   logic [hsm_pkg::TEMP_W-1:0]    min_rise_ff;

   // monitor state
   logic [hsm_pkg::FLAG_W-1:0]    live_ff, live_in;
   logic [hsm_pkg::FLAG_W-1:0]    sticky_ff, sticky_in;
   logic                          armed_ff, armed_in;
   logic [hsm_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [hsm_pkg::TEMP_W-1:0]    start_ff, start_in;
   logic                          heater_ff, heater_in;

   logic                          over_temp;
   logic                          watch;
   logic [hsm_pkg::ELAPSED_W-1:0] elapsed_sum;
   logic                          window_done;
   logic signed [hsm_pkg::TEMP_W:0] rise;
   logic                          too_slow;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff <= hsm_pkg::RST_MAX_TEMPERATURE;
         duty_thr_ff <= hsm_pkg::RST_DUTY_THRESHOLD;
         window_ff   <= hsm_pkg::RST_WINDOW_MS;
         min_rise_ff <= hsm_pkg::RST_MIN_RISE;
      end else if (csr.wen) begin
         case (csr.index)
            hsm_pkg::REG_MAX_TEMPERATURE: begin
               max_temp_ff <= csr.wdata[hsm_pkg::TEMP_W-1:0];
            end
            hsm_pkg::REG_DUTY_THRESHOLD: begin
               duty_thr_ff <= csr.wdata[hsm_pkg::DUTY_W-1:0];
            end
            hsm_pkg::REG_WINDOW_MS: begin
               window_ff <= csr.wdata;
            end
            hsm_pkg::REG_MIN_RISE: begin
               min_rise_ff <= csr.wdata[hsm_pkg::TEMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign over_temp   = $signed(item.temperature) > $signed(max_temp_ff);
   assign watch       = !item.sensor_bad && (item.duty >= duty_thr_ff);
   assign elapsed_sum = elapsed_ff + hsm_pkg::ELAPSED_W'(item.step_ms);
   assign window_done = elapsed_sum >= {1'b0, window_ff};
   // 17-bit difference, no wrap
   assign rise        = $signed({item.temperature[hsm_pkg::TEMP_W-1], item.temperature})
                      - $signed({start_ff[hsm_pkg::TEMP_W-1], start_ff});
   assign too_slow    = rise < $signed({min_rise_ff[hsm_pkg::TEMP_W-1], min_rise_ff});

   always_comb begin
      live_in    = live_ff;
      sticky_in  = sticky_ff;
      armed_in   = armed_ff;
      elapsed_in = elapsed_ff;
      start_in   = start_ff;
      heater_in  = heater_ff;
      case (item.opcode)
         hsm_pkg::OP_CLEAR: begin
            sticky_in = '0;
         end
         hsm_pkg::OP_EVALUATE: begin
            live_in = '0;
            live_in[hsm_pkg::FLAG_SENSOR] = item.sensor_bad;
            live_in[hsm_pkg::FLAG_OVER]   = !item.sensor_bad && over_temp;
            if (watch) begin
               if (!armed_ff) begin
                  // arming sample: start a window, no check
                  armed_in   = 1'b1;
                  elapsed_in = '0;
                  start_in   = item.temperature;
               end else if (window_done) begin
                  live_in[hsm_pkg::FLAG_RUNAWAY] = too_slow;
                  elapsed_in = '0;
                  start_in   = item.temperature;
               end else begin
                  elapsed_in = elapsed_sum;
               end
            end else begin
               armed_in = 1'b0;
            end
            sticky_in = sticky_ff | live_in;
            if (sticky_in == '0) begin
               heater_in = 1'b1;
            end else if (live_in != '0) begin
               heater_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff    <= '0;
         sticky_ff  <= '0;
         armed_ff   <= 1'b0;
         elapsed_ff <= '0;
         start_ff   <= '0;
         heater_ff  <= 1'b0;
      end else if (fire) begin
         live_ff    <= live_in;
         sticky_ff  <= sticky_in;
         armed_ff   <= armed_in;
         elapsed_ff <= elapsed_in;
         start_ff   <= start_in;
         heater_ff  <= heater_in;
      end
   end

   assign result.fault_flags   = live_in | sticky_in;
   assign result.latched_flags = sticky_in;
   assign result.heater_enable = heater_in;

`ifndef SYNTHESIS
   a_heater_needs_clean: assert property (@(posedge clock) disable iff (reset)
      heater_ff |-> (sticky_ff == '0))
      else $error("heater enabled with latched faults");

   a_sensor_alone: assert property (@(posedge clock) disable iff (reset)
      live_ff[hsm_pkg::FLAG_SENSOR] |->
         (!live_ff[hsm_pkg::FLAG_OVER] && !live_ff[hsm_pkg::FLAG_RUNAWAY]))
      else $error("sensor fault raised together with another fault");

   a_bad_disarms: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.opcode == hsm_pkg::OP_EVALUATE) && item.sensor_bad) |=> !armed_ff)
      else $error("runaway watch still armed after bad sensor");

   a_fault_kills_heater: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.opcode == hsm_pkg::OP_EVALUATE) && (live_in != '0)) |=> !heater_ff)
      else $error("heater left on after a fault");
`endif

endmodule

>>> hdl/heater_safety_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_safety_monitor: thermal runaway protection for a heater
// Stream in samples or clear commands, stream out fault and heater status.
// ----------------------------------------------------------------------------
// Takes one transfer per clock and returns one result transfer for each, in
// order. A transfer lands in the input register, is evaluated in one pass of
// compare/add logic against the monitor state, and the result is held in the
// output register until rsp_tready takes it. The input register keeps
// accepting while a result waits, so a stalled consumer costs at most one
// slot before req_tready drops. An evaluate (req_tuser = 0) clears live faults
// and raises sensor, over-temperature or runaway faults; each fault sets a
// latched bit and forces the heater off, and the heater comes back only on
// an evaluate that finds no latched bit. A clear (req_tuser = 1) wipes the
// latched bits only. Registers (index: 0 trip temperature, 1 duty arm
// level, 2 window ms, 3 min rise) are set via csr_wen/csr_index/csr_wdata;
// the user must write them only while the block is idle; it does not check.
// ----------------------------------------------------------------------------
module heater_safety_monitor (
   input  logic                                    clock,
   input  logic                                    reset,
   // request stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // tdata: temperature[15:0], duty[31:16], step_ms[47:32], sensor_bad[48]
   input  logic [hsm_pkg::REQ_DATA_W-1:0]          req_tdata,
   // tuser: opcode[0]
   input  logic                                    req_tuser,
   // result stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // tdata: fault_flags[2:0], latched_flags[5:3], heater_enable[6]
   output logic [hsm_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // configuration writes
   input  logic                                    csr_wen,
   input  logic [hsm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [hsm_pkg::CSR_DAT_W-1:0]           csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   hsm_pkg::item_type     in_item_ff;
   hsm_pkg::item_type     req_item;
   logic                  out_valid_ff, out_valid_in;
   hsm_pkg::result_type   out_res_ff;
   hsm_pkg::result_type   eval_res;
   hsm_pkg::csr_write_type csr;
   logic                  advance;
   logic                  req_xfer;

   // unpack request transfer
   assign req_item.opcode      = hsm_pkg::opcode_type'(req_tuser);
   assign req_item.temperature = req_tdata[15:0];
   assign req_item.duty        = req_tdata[31:16];
   assign req_item.step_ms     = req_tdata[47:32];
   assign req_item.sensor_bad  = req_tdata[48];

   assign csr.wen   = csr_wen;
   assign csr.index = hsm_pkg::reg_index_type'(csr_index);
   assign csr.wdata = csr_wdata;

   // item moves from input register to output register when the slot frees
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_res_ff <= eval_res;
      end
   end

   hsm_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (advance),
      .item   (in_item_ff),
      .result (eval_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_res_ff.heater_enable, out_res_ff.latched_flags,
                        out_res_ff.fault_flags};

`ifndef SYNTHESIS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("result overwritten while stalled");

   a_fill_one_per_xfer: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("input register accepts while holding an item");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated item produced no result");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the heater safety monitor
// Streams directed and random evaluate/clear transfers into the block under
// several register settings and idle patterns. A local copy of the monitor
// state predicts every status transfer, and the output stream is compared
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned PHASE_ITEMS    = 100;
   localparam int unsigned HOLD_CYCLES    = 300;   // long consumer back-pressure
   localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles without any transfer

   localparam hsm_pkg::opcode_type OP_EVAL = hsm_pkg::OP_EVALUATE;
   localparam hsm_pkg::opcode_type OP_CLR  = hsm_pkg::OP_CLEAR;

   // ------------------------------------------------------------------------
   // clock, reset and block I/O; every input starts at a known value
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [hsm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [hsm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wen    = 1'b0;
   logic [hsm_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [hsm_pkg::CSR_DAT_W-1:0]  csr_wdata  = '0;

   always #1 clock = ~clock;

   heater_safety_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // bench-side copy of the monitor: registers and state
   // ------------------------------------------------------------------------
   logic signed [hsm_pkg::TEMP_W-1:0] trip_temp  = hsm_pkg::RST_MAX_TEMPERATURE;
   logic [hsm_pkg::DUTY_W-1:0]        arm_duty   = hsm_pkg::RST_DUTY_THRESHOLD;
   logic [hsm_pkg::WINDOW_W-1:0]      window_len = hsm_pkg::RST_WINDOW_MS;
   logic signed [hsm_pkg::TEMP_W-1:0] min_rise   = hsm_pkg::RST_MIN_RISE;

   logic [hsm_pkg::FLAG_W-1:0]        live_flags   = '0;
   logic [hsm_pkg::FLAG_W-1:0]        sticky_flags = '0;
   logic                              watching     = 1'b0;
   logic [hsm_pkg::ELAPSED_W-1:0]     elapsed_ms   = '0;
   logic signed [hsm_pkg::TEMP_W-1:0] start_temp   = '0;
   logic                              heater_on    = 1'b0;

   // stimulus and scoreboard storage
   hsm_pkg::item_type   sample_q[$];     // transfers not yet offered
   hsm_pkg::result_type status_q[$];     // predicted status, oldest first
   hsm_pkg::item_type   cur_item;        // transfer currently on the request bus
   logic                req_taken = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic        hold_start     = 1'b0;
   int unsigned hold_left      = 0;

   int unsigned mismatch_count = 0;
   int unsigned rsp_count      = 0;
   int unsigned idle_cycles    = 0;
   int          walk_temp      = 0;

   function automatic void raise_flag(int unsigned pos);
      live_flags[pos]   = 1'b1;
      sticky_flags[pos] = 1'b1;
      heater_on         = 1'b0;
   endfunction

   // status produced by one accepted transfer; advances the local state
   function automatic hsm_pkg::result_type status_after(hsm_pkg::item_type it);
      hsm_pkg::result_type r;
      int                  rise;
      if (it.opcode == hsm_pkg::OP_CLEAR) begin
         sticky_flags = '0;
      end else begin
         live_flags = '0;
         if (it.sensor_bad)
            raise_flag(hsm_pkg::FLAG_SENSOR);
         if (!it.sensor_bad && $signed(it.temperature) > $signed(trip_temp))
            raise_flag(hsm_pkg::FLAG_OVER);
         if (!it.sensor_bad && it.duty >= arm_duty) begin
            if (!watching) begin
               // arming sample: record start point only, no check
               watching   = 1'b1;
               elapsed_ms = '0;
               start_temp = it.temperature;
            end else begin
               elapsed_ms = elapsed_ms + it.step_ms;
               if (elapsed_ms >= {1'b0, window_len}) begin
                  // full-precision difference, strict compare
                  rise = int'($signed(it.temperature)) - int'($signed(start_temp));
                  if (rise < int'($signed(min_rise)))
                     raise_flag(hsm_pkg::FLAG_RUNAWAY);
                  elapsed_ms = '0;
                  start_temp = it.temperature;
               end
            end
         end else begin
            watching = 1'b0;
         end
         if (sticky_flags == '0)
            heater_on = 1'b1;
      end
      r.fault_flags   = live_flags | sticky_flags;
      r.latched_flags = sticky_flags;
      r.heater_enable = heater_on;
      return r;
   endfunction

   function automatic hsm_pkg::item_type make_item(hsm_pkg::opcode_type op, int t,
                                                   int unsigned d, int unsigned s,
                                                   bit bad);
      hsm_pkg::item_type it;
      it.opcode      = op;
      it.temperature = t[hsm_pkg::TEMP_W-1:0];
      it.duty        = d[hsm_pkg::DUTY_W-1:0];
      it.step_ms     = s[hsm_pkg::STEP_W-1:0];
      it.sensor_bad  = bad;
      return it;
   endfunction

   // Random sample: mostly a slow temperature walk with duty above the arm
   // level and steps sized to the window, so runaway checks really happen.
   // The rest jumps anywhere, sits at the trip level, or clears latches.
   function automatic hsm_pkg::item_type random_item();
      hsm_pkg::item_type it;
      int unsigned       pick;
      int unsigned       span;
      pick = $urandom_range(99);
      if (pick < 5)
         walk_temp = int'($urandom_range(40959)) - 8192;
      else if (pick < 12)
         walk_temp = int'($signed(trip_temp)) + int'($urandom_range(4)) - 2;
      else
         walk_temp = walk_temp + int'($urandom_range(24)) - 8;
      if (walk_temp < -8192) walk_temp = -8192;
      if (walk_temp > 32767) walk_temp = 32767;

      it.opcode      = ($urandom_range(99) < 6) ? OP_CLR : OP_EVAL;
      it.sensor_bad  = ($urandom_range(99) < 5);
      it.temperature = walk_temp[hsm_pkg::TEMP_W-1:0];
      it.duty        = ($urandom_range(99) < 75)
                     ? hsm_pkg::DUTY_W'($urandom_range(65535, arm_duty))
                     : hsm_pkg::DUTY_W'($urandom_range(65535));
      span = (window_len / 3) + 1;
      if (span > 65535) span = 65535;
      it.step_ms     = ($urandom_range(99) < 85)
                     ? hsm_pkg::STEP_W'($urandom_range(span))
                     : hsm_pkg::STEP_W'($urandom_range(65535));
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: new transfer offered at the falling edge once the
   // previous one was taken; valid never drops while a transfer is pending
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item = sample_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {7'b0, cur_item.sensor_bad, cur_item.step_ms,
                           cur_item.duty, cur_item.temperature};
            req_tuser  <= cur_item.opcode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result consumer: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: predicts on each request transfer, checks each status transfer,
   // and runs the no-progress watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      hsm_pkg::result_type want;
      req_taken = req_tvalid && req_tready;
      if (!reset) begin
         if (req_taken)
            status_q.push_back(status_after(cur_item));

         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("status %0d: unexpected transfer, tdata %h",
                           rsp_count, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               if (rsp_tdata[2:0] !== want.fault_flags ||
                   rsp_tdata[5:3] !== want.latched_flags ||
                   rsp_tdata[6]   !== want.heater_enable) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"status %0d: fault_flags exp %b got %b, ",
                               "latched_flags exp %b got %b, ",
                               "heater_enable exp %b got %b"},
                              rsp_count, want.fault_flags, rsp_tdata[2:0],
                              want.latched_flags, rsp_tdata[5:3],
                              want.heater_enable, rsp_tdata[6]);
               end
            end
            rsp_count++;
         end

         if (req_taken || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------------
   // register writes land at the falling edge; the local copy follows at once
   // since the block is idle whenever this runs
   task automatic write_reg(hsm_pkg::reg_index_type idx,
                            logic [hsm_pkg::CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         hsm_pkg::REG_MAX_TEMPERATURE: trip_temp  = val[hsm_pkg::TEMP_W-1:0];
         hsm_pkg::REG_DUTY_THRESHOLD:  arm_duty   = val[hsm_pkg::DUTY_W-1:0];
         hsm_pkg::REG_WINDOW_MS:       window_len = val[hsm_pkg::WINDOW_W-1:0];
         hsm_pkg::REG_MIN_RISE:        min_rise   = val[hsm_pkg::TEMP_W-1:0];
         default: ;
      endcase
   endtask

   // sender stays quiet until every predicted status has come back; checked
   // at the rising edge, where the request bus and the queues are settled
   task automatic drain();
      @(posedge clock);
      while (sample_q.size() != 0 || req_tvalid || status_q.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);   // two-stage pipe, plus margin
   endtask

   task automatic run_phase(logic [15:0] trip, logic [15:0] arm, logic [23:0] win,
                            logic [15:0] rise, int unsigned send_pct,
                            int unsigned recv_pct, bit long_hold);
      write_reg(hsm_pkg::REG_MAX_TEMPERATURE, {8'h00, trip});
      write_reg(hsm_pkg::REG_DUTY_THRESHOLD,  {8'h00, arm});
      write_reg(hsm_pkg::REG_WINDOW_MS,       win);
      write_reg(hsm_pkg::REG_MIN_RISE,        {8'h00, rise});
      @(negedge clock);
      csr_wen <= 1'b0;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      walk_temp      = int'($signed(trip_temp)) - 200;
      if (long_hold)
         hold_start = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
         sample_q.push_back(random_item());
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, reset register values: trip 4800, arm 32768, window 60000,
      // min rise 32. Walks through trip-level boundary, latch and clear,
      // sensor fault masking, arming, a short rise and an exact rise, and
      // 17-bit wide differences in both directions.
      sample_q.push_back(make_item(OP_EVAL,     0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,  4800,     0,     0, 1'b0)); // at trip: ok
      sample_q.push_back(make_item(OP_EVAL,  4801,     0,     0, 1'b0)); // over
      sample_q.push_back(make_item(OP_EVAL,   100,     0,     0, 1'b0)); // latched only
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0)); // heater stays off
      sample_q.push_back(make_item(OP_EVAL,   100,     0,     0, 1'b0)); // heater back on
      sample_q.push_back(make_item(OP_EVAL, 32767, 65535, 65535, 1'b1)); // sensor only
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL, -8192,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,  1000, 32768, 65535, 1'b0)); // arm, no check
      sample_q.push_back(make_item(OP_EVAL,  1010, 65535, 30000, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,  1031, 40000, 30000, 1'b0)); // rise 31: runaway
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,  1063, 50000, 60000, 1'b0)); // rise 32: ok
      sample_q.push_back(make_item(OP_EVAL,  1063, 32767,   100, 1'b0)); // disarm
      sample_q.push_back(make_item(OP_EVAL, -8192, 65535,     0, 1'b0)); // arm low
      sample_q.push_back(make_item(OP_EVAL, 32767, 65535, 65535, 1'b0)); // big rise, over
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL, -8192, 65535, 60000, 1'b0)); // big fall
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,     0,     0,     0, 1'b0));
      sample_q.push_back(make_item(OP_EVAL,    -1, 65535,     1, 1'b1));
      sample_q.push_back(make_item(OP_CLR,      0,     0,     0, 1'b0));
      drain();

      // random phases: trip, arm, window, min rise, sender idle %, consumer
      // stall %, long hold-off
      run_phase(16'd4800,   16'd32768, 24'd200,      16'd32,     75,  0, 1'b0);
      run_phase(16'hE000,   16'd0,     24'd0,        16'h7FFF,    0, 75, 1'b1);
      run_phase(16'h7FFF,   16'hFFFF,  24'hFFFFFF,   16'hE000,    8,  8, 1'b0);
      run_phase(16'd1600,   16'd20000, 24'd500,      16'd16,      0,  0, 1'b0);
      run_phase(16'd0,      16'd40000, 24'd1,        16'hFFFF,   75,  0, 1'b0);
      run_phase(16'd2000,   16'd1000,  24'd3000,     16'd64,      0, 75, 1'b1);
      run_phase(16'h7FFF,   16'd0,     24'd100000,   16'd0,       8,  8, 1'b0);
      run_phase(16'd4800,   16'd32768, 24'd60000,    16'd32,      0,  0, 1'b0);

      repeat (10) @(negedge clock);
      mismatch_count += status_q.size();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/hsm_pkg.sv
hdl/hsm_eval.sv
hdl/heater_safety_monitor.sv
dv/tb_top.sv
